// ===== rtl/evad_pkg.sv =====
package evad_pkg;

  localparam int WindowDepth = 16384;
  localparam int PtrBits = 14;
  localparam int CountBits = 24;
  localparam int SqBits = 31;
  localparam int WinSumBits = 45;
  localparam int TotSumBits = 54;
  localparam logic [15:0] NoiseAlpha = 16'd655;
  localparam logic [16:0] NoiseKeep = 17'd64881;
  localparam logic [15:0] NoiseMin = 16'd6554;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegHpfEn = 2'd1;
  localparam logic [1:0] RegAlpha = 2'd2;
  localparam logic [1:0] RegThresh = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic silent;
    logic too_short;
    logic [15:0] rms_window;
    logic [15:0] rms_before;
    logic [15:0] floor_level;
  } out_item_t;

endpackage

// ===== rtl/energy_voice_activity_detector.sv =====
// Energy voice activity detector. Takes one Q1.15 sample per item; squares
// go to a ring memory of 16384 entries, so an ordinary sample passes through
// accept, multiply with the RAM read of the leaving square, ring write and
// update of the sums, during which the input stalls. A sample marked last
// adds the RMS work: two mean divisions of 54 bits (one quotient bit per
// cycle after a set-up step), two 32-bit square roots and the decision,
// after which the result item is offered (a buffer no longer than the window
// is flagged too short without it); the input is open again in the cycle
// after the result item is taken. No clearing pass is needed after reset.
module energy_voice_activity_detector
  import evad_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_SQ   = 8'b00000100,
    S_ACC  = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_SQRT = 8'b00100000,
    S_DEC  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic [14:0] window_length;
  logic hpf_enable;
  logic [15:0] hpf_alpha, vad_threshold;

  logic signed [15:0] prev_in, prev_out, y;
  logic at_start, last;
  logic [PtrBits-1:0] ring_pointer;
  logic [14:0] win;
  logic [CountBits-1:0] sample_count;
  logic [WinSumBits-1:0] window_sum;
  logic [TotSumBits-1:0] total_sum;
  logic [15:0] noise_level;
  logic [SqBits-1:0] sq;

  logic [SqBits-1:0] ring_rd;
  logic ring_we;
  logic [PtrBits-1:0] old_addr;

  // divider / root
  logic phase;
  logic [5:0] cnt;
  logic [TotSumBits-1:0] dividend;
  logic [CountBits:0] rem, divisor;
  logic [31:0] scaled;
  logic [33:0] rr;
  logic [15:0] root, rw, rb;
  logic out_short, out_silent;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT) && (cnt != 6'd63);
  assign out_data = '{silent: out_silent, too_short: out_short, rms_window: rw,
                      rms_before: rb, floor_level: noise_level};

  assign old_addr = ring_pointer - win[PtrBits-1:0];
  assign ring_we = (state == S_SQ);

  evad_ram #(.Width(SqBits), .Depth(WindowDepth)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_pointer), .wdata(sq),
    .raddr(old_addr), .rdata(ring_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 15'd8000;
      hpf_enable <= 1'b1;
      hpf_alpha <= 16'd63058;
      vad_threshold <= 16'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWindow: window_length <= cfg_data[14:0];
        RegHpfEn:  hpf_enable <= cfg_data[0];
        RegAlpha:  hpf_alpha <= cfg_data;
        RegThresh: vad_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [17:0] diff;
  logic signed [34:0] fprod;
  logic signed [34:0] frnd;
  logic signed [18:0] fq;
  logic signed [15:0] fsat;
  logic [WinSumBits-1:0] ws_sub;
  logic [TotSumBits:0] ts_add;
  logic [TotSumBits-1:0] before_sum;
  logic [CountBits-1:0] nb;
  logic [CountBits:0] trial;
  logic [32:0] nsum;
  logic [15:0] refl;
  logic [32:0] lhs, rhs;

  always_comb begin
    diff = 18'(prev_out) + 18'(in_data.sample) - 18'(prev_in);
    fprod = $signed({1'b0, hpf_alpha}) * diff;
    frnd = fprod + 35'sd32768;
    fq = 19'(frnd >>> 16);
    if (fq > 19'sd32767) fsat = 16'sd32767;
    else if (fq < -19'sd32768) fsat = -16'sd32768;
    else fsat = fq[15:0];
    ws_sub = (sample_count >= CountBits'(win)) ?
             ((window_sum >= WinSumBits'(ring_rd)) ? window_sum - WinSumBits'(ring_rd) : '0)
             : window_sum;
    ts_add = {1'b0, total_sum} + (TotSumBits+1)'(sq);
    before_sum = (total_sum >= TotSumBits'(window_sum)) ?
                 total_sum - TotSumBits'(window_sum) : '0;
    nb = sample_count - CountBits'(win);
    trial = {rem[CountBits-1:0], dividend[TotSumBits-1]};
    nsum = 33'(NoiseAlpha) * 33'(rb) + 33'(NoiseKeep) * 33'(noise_level) + 33'd32768;
    refl = (rb > noise_level) ? rb : noise_level;
    lhs = 33'(rw) * 33'(vad_threshold);
    rhs = {9'b0, refl, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      at_start <= 1'b1;
      prev_in <= '0;
      prev_out <= '0;
      ring_pointer <= '0;
      sample_count <= '0;
      window_sum <= '0;
      total_sum <= '0;
      noise_level <= '0;
      win <= 15'd1;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          last <= in_data.last;
          prev_in <= in_data.sample;
          if (at_start) begin
            y <= in_data.sample;
            prev_out <= '0;
            at_start <= 1'b0;
            if (window_length == 15'd0) win <= 15'd1;
            else if (window_length > 15'(WindowDepth)) win <= 15'(WindowDepth);
            else win <= window_length;
          end else if (hpf_enable) begin
            y <= fsat;
            prev_out <= fsat;
          end else begin
            y <= in_data.sample;
          end
          state <= S_RD;
        end
        S_RD: begin
          sq <= SqBits'(y * y);
          state <= S_SQ;
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          window_sum <= ws_sub + WinSumBits'(sq);
          total_sum <= ts_add[TotSumBits] ? '1 : ts_add[TotSumBits-1:0];
          ring_pointer <= ring_pointer + 1'b1;
          if (sample_count != '1) sample_count <= sample_count + 1'b1;
          if (!last) state <= S_IDLE;
          else if (sample_count + 1'b1 <= CountBits'(win) && sample_count != '1) begin
            out_short <= 1'b1; out_silent <= 1'b0; rw <= '0; rb <= '0;
            cnt <= 6'd0;
            state <= S_OUT;
          end else begin
            out_short <= 1'b0;
            phase <= 1'b0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          // start one division: window first, then before part
          cnt <= 6'd0;
          rem <= '0;
          if (!phase) begin
            dividend <= TotSumBits'(window_sum);
            divisor <= (CountBits+1)'(win);
          end else begin
            dividend <= before_sum;
            divisor <= {1'b0, nb};
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial >= divisor) begin
            rem <= trial - divisor;
            dividend <= {dividend[TotSumBits-2:0], 1'b1};
          end else begin
            rem <= trial;
            dividend <= {dividend[TotSumBits-2:0], 1'b0};
          end
          if (cnt == 6'(TotSumBits-1)) begin
            cnt <= 6'd0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            scaled <= (dividend >= TotSumBits'(32'h4000_0000)) ? 32'hFFFF_FFFC
                      : {dividend[29:0], 2'b00};
            rr <= '0; root <= '0;
            cnt <= 6'd1;
          end else if (cnt <= 6'd16) begin
            scaled <= {scaled[29:0], 2'b00};
            cnt <= cnt + 1'b1;
            if ({rr[31:0], scaled[31:30]} >= {16'b0, root, 2'b01}) begin
              rr <= {rr[31:0], scaled[31:30]} - {16'b0, root, 2'b01};
              root <= {root[14:0], 1'b1};
            end else begin
              rr <= {rr[31:0], scaled[31:30]};
              root <= {root[14:0], 1'b0};
            end
          end else begin
            if (!phase) begin
              rw <= root; phase <= 1'b1; state <= S_DEC;
            end else begin
              rb <= (nb == '0) ? '0 : root; phase <= 1'b0;
              out_silent <= 1'b0;
              cnt <= 6'd63;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (cnt == 6'd63) begin
            cnt <= 6'd0;
            if (lhs < rhs) begin
              out_silent <= 1'b1;
              if (nsum[32:16] < 17'(NoiseMin)) noise_level <= NoiseMin;
              else if (nsum[32] ) noise_level <= 16'hFFFF;
              else noise_level <= nsum[31:16];
            end
          end else if (!out_stall) begin
            at_start <= 1'b1;
            prev_in <= '0; prev_out <= '0;
            ring_pointer <= '0; sample_count <= '0;
            window_sum <= '0; total_sum <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/evad_ram.sv =====
module evad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== bench/energy_voice_activity_detector_tb.sv =====
module energy_voice_activity_detector_tb;
  import evad_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = RegWindow;
  logic [15:0] cfg_data = '0;

  energy_voice_activity_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  in_item_t sample_q[$];
  out_item_t decision_q[$];
  int mismatches = 0;
  bit gaps_on = 1'b1;

  int unsigned win_reg = 8000, hpf_en_reg = 1, alpha_reg = 63058, thresh_reg = 512;
  longint prev_in = 0, prev_out = 0;
  bit at_start = 1'b1;
  longint unsigned sq_ring[WindowDepth];
  int unsigned ring_ptr = 0, win_lat = 1;
  longint unsigned count = 0, win_sum = 0, tot_sum = 0;
  int unsigned noise = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned rms_of(longint unsigned sum, longint unsigned n);
    longint unsigned mean, r;
    if (n == 0) return 0;
    mean = sum / n;
    if (mean > (64'd1 << 30)) mean = 64'd1 << 30;
    r = isqrt(mean << 2);
    return (r > 65535) ? 65535 : int'(r);
  endfunction

  task automatic predict_decision(in_item_t it);
    longint x, y, d;
    longint unsigned sq, before_sum;
    int unsigned old, rw, rb, lvl;
    longint unsigned nn;
    bit sil;
    out_item_t e;
    x = longint'(it.sample);
    if (at_start) begin
      win_lat = (win_reg == 0) ? 1 : ((win_reg > WindowDepth) ? WindowDepth : win_reg);
      y = x;
      prev_out = 0;
      at_start = 1'b0;
    end else if (hpf_en_reg != 0) begin
      d = prev_out + x - prev_in;
      y = (longint'(alpha_reg) * d + 32768) >>> 16;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      prev_out = y;
    end else begin
      y = x;
    end
    prev_in = x;
    sq = longint'(y * y);
    if (count >= win_lat) begin
      old = (ring_ptr + WindowDepth - win_lat) % WindowDepth;
      win_sum = (win_sum >= sq_ring[old]) ? win_sum - sq_ring[old] : 0;
    end
    sq_ring[ring_ptr] = sq;
    win_sum += sq;
    tot_sum += sq;
    ring_ptr = (ring_ptr + 1) % WindowDepth;
    if (count < (64'd1 << CountBits) - 1) count++;
    if (!it.last) return;
    e = '0;
    if (count <= win_lat) begin
      e.too_short = 1'b1;
      e.floor_level = noise[15:0];
    end else begin
      before_sum = (tot_sum >= win_sum) ? tot_sum - win_sum : 0;
      rw = rms_of(win_sum, win_lat);
      rb = rms_of(before_sum, count - win_lat);
      lvl = (rb > noise) ? rb : noise;
      sil = (longint'(rw) * thresh_reg) < (longint'(lvl) << 8);
      if (sil) begin
        nn = (655 * longint'(rb) + 64881 * longint'(noise) + 32768) >> 16;
        if (nn < 6554) nn = 6554;
        if (nn > 65535) nn = 65535;
        noise = int'(nn);
      end
      e.silent = sil;
      e.rms_window = rw[15:0];
      e.rms_before = rb[15:0];
      e.floor_level = noise[15:0];
    end
    decision_q.push_back(e);
    prev_in = 0;
    prev_out = 0;
    at_start = 1'b1;
    ring_ptr = 0;
    count = 0;
    win_sum = 0;
    tot_sum = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_decision(in_data);
      if (!in_valid || !in_stall) begin
        if (sample_q.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 6)) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
    if (!rst && out_valid && !out_stall) begin
      if (decision_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = decision_q.pop_front();
        if (e.silent !== out_data.silent || e.too_short !== out_data.too_short ||
            e.rms_window !== out_data.rms_window || e.rms_before !== out_data.rms_before ||
            e.floor_level !== out_data.floor_level) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegWindow: win_reg = val & 16'h7fff;
      RegHpfEn: hpf_en_reg = val & 16'h1;
      RegAlpha: alpha_reg = val;
      RegThresh: thresh_reg = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (sample_q.size() > 0 || in_valid || decision_q.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] s, logic l);
    in_item_t it;
    it.sample = s;
    it.last = l;
    sample_q.push_back(it);
  endtask

  task automatic push_buffer(int len, int tail, bit quiet_tail);
    int amp;
    for (int i = 0; i < len; i++) begin
      amp = (quiet_tail && i >= len - tail) ? $urandom_range(0, 300) : 32767;
      if ($urandom_range(0, 9) == 0) push_sample(16'($urandom), i == len - 1);
      else push_sample(16'($signed($urandom_range(0, 2 * amp)) - amp), i == len - 1);
    end
  endtask

  task automatic set_all(int w, int en, int a, int t);
    write_reg(RegWindow, 16'(w));
    write_reg(RegHpfEn, 16'(en));
    write_reg(RegAlpha, 16'(a));
    write_reg(RegThresh, 16'(t));
  endtask

  initial begin
    int w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    push_sample(16'sd1000, 1'b1);
    drain();
    set_all(2, 0, 65535, 512);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd3, 1'b1);
    push_sample(-16'sd32768, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(-16'sd32768, 1'b1);
    drain();
    set_all(0, 1, 65535, 0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b1);
    drain();
    set_all(3, 1, 0, 65535);
    push_buffer(8, 3, 1'b1);
    drain();
    set_all(16384, 1, 63058, 512);
    push_buffer(20, 4, 1'b0);
    drain();
    set_all(32767, 0, 63058, 256);
    push_buffer(24, 10, 1'b1);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph != 5 && ph != 6);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
      set_all(w, $urandom_range(0, 1),
              ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535),
              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 600) : $urandom_range(0, 65535));
      for (int b = 0; b < 5; b++) begin
        if (b == 2) begin
          drain();
          write_reg(RegAlpha, 16'($urandom_range(0, 65535)));
        end
        push_buffer($urandom_range(1, 3 * (w + 1) + 6), w + $urandom_range(0, 1),
                    1'($urandom_range(0, 1)));
      end
      drain();
    end
    gaps_on = 1'b1;
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
